/* rtl/core/gbn_pkg.sv */
// Shared types and constants for the go-back-n sender.
// No dependencies; every other file in rtl/core uses it.
`default_nettype none

package gbn_pkg;

    // field widths fixed by the item format
    localparam int OP_W    = 1;
    localparam int BYTE_W  = 8;
    localparam int SEQ_W   = 6;
    localparam int WIN_W   = 4;

    // an item never yields more frames than this
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd4;

    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_ACK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAN,
        ST_READ,
        ST_SHOW
    } gbn_state_t;

endpackage

`default_nettype wire

/* rtl/core/gbn_ifs.sv */
// Valid/ready channel interfaces for the go-back-n sender.
// Depends on gbn_pkg for field widths.
`default_nettype none

interface gbn_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [gbn_pkg::OP_W-1:0]      operation;
    logic [gbn_pkg::BYTE_W-1:0]    data_byte;
    logic [gbn_pkg::SEQ_W-1:0]     ack_seq;
    modport source (output valid, output operation, output data_byte, output ack_seq,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input ack_seq,
                    output ready);
endinterface

interface gbn_frame_if;
    logic                          valid;
    logic                          ready;
    logic [gbn_pkg::SEQ_W-1:0]     frame_seq;
    logic [gbn_pkg::BYTE_W-1:0]    frame_data;
    logic                          is_resend;
    logic                          last;
    modport source (output valid, output frame_seq, output frame_data,
                    output is_resend, output last, input ready);
    modport sink   (input valid, input frame_seq, input frame_data,
                    input is_resend, input last, output ready);
endinterface

interface gbn_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gbn_pkg::WIN_W-1:0]     win_size;
    modport source (output valid, output win_size, input ready);
    modport sink   (input valid, input win_size, output ready);
endinterface

`default_nettype wire

/* rtl/core/gbn_store.sv */
// Frame byte store: one write port, one read port, registered read data.
// Depends on gbn_pkg.
`default_nettype none

module gbn_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  wire logic [gbn_pkg::BYTE_W-1:0]      wr_data,
    input  wire logic                            rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
    output      logic [gbn_pkg::BYTE_W-1:0]      rd_data
);

    logic [gbn_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [gbn_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/gbn_run_calc.sv */
// Run length of one item: resends from the base plus new frames that fit
// the window, capped at the per-item maximum. Depends on gbn_pkg.
`default_nettype none

module gbn_run_calc #(
    parameter int IDX_W      = 7,
    parameter int MAX_WINDOW = 8
) (
    input  wire logic [IDX_W-1:0]             base,
    input  wire logic [IDX_W-1:0]             next_idx,
    input  wire logic [IDX_W-1:0]             loaded,
    input  wire logic [gbn_pkg::WIN_W-1:0]    win_size,
    input  wire logic                         with_resend,
    output      logic [gbn_pkg::CNT_W-1:0]    count
);

    localparam int WCAP = (MAX_WINDOW < gbn_pkg::MAX_RESULTS) ?
                          MAX_WINDOW : gbn_pkg::MAX_RESULTS;
    localparam logic [gbn_pkg::WIN_W-1:0] WCAP_V = gbn_pkg::WIN_W'(WCAP);
    localparam logic [IDX_W:0]            MAXR_W = (IDX_W+1)'(gbn_pkg::MAX_RESULTS);

    logic [gbn_pkg::WIN_W-1:0] win_eff;
    logic [IDX_W:0]            limit;
    logic [IDX_W:0]            hi;
    logic [IDX_W:0]            n_new;
    logic [IDX_W:0]            n_res;
    logic [4:0]                new_c;
    logic [4:0]                res_c;
    logic [4:0]                total;

    always_comb
    begin
        // zero acts as one, large values saturate
        if (win_size == '0)
            win_eff = gbn_pkg::WIN_W'(1);
        else if (win_size > WCAP_V)
            win_eff = WCAP_V;
        else
            win_eff = win_size;

        limit = {1'b0, base} + (IDX_W+1)'(win_eff);
        hi    = (limit < {1'b0, loaded}) ? limit : {1'b0, loaded};
        n_new = (hi > {1'b0, next_idx}) ? (hi - {1'b0, next_idx}) : '0;
        n_res = with_resend ? ({1'b0, next_idx} - {1'b0, base}) : '0;

        new_c = (n_new > MAXR_W) ? 5'(gbn_pkg::MAX_RESULTS) : 5'(n_new);
        res_c = (n_res > MAXR_W) ? 5'(gbn_pkg::MAX_RESULTS) : 5'(n_res);
        total = res_c + new_c;
        if (total > 5'(gbn_pkg::MAX_RESULTS))
            total = 5'(gbn_pkg::MAX_RESULTS);
        count = total[gbn_pkg::CNT_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/core/go_back_n_sender.sv */
// Go-back-n sender. A load item appends a byte to the frame store and sends
// it when the window has room; an ack item slides the window base past the
// acked frame (if it is outstanding), resends every outstanding frame from the
// base and then sends stored frames until the window is full, at most eight
// frames per item. The item is taken in ST_IDLE, the run length is worked out
// in ST_PLAN, then each frame is read from the store (ST_READ) and presented
// (ST_SHOW), waiting there on frame.ready. A load into a full store is dropped
// in ST_IDLE; any other item with no frames returns to ST_IDLE from ST_PLAN.
// cmd.ready is low for the whole run, and the store read port is the pacing
// unit. The store has no clearing pass: only entries already loaded are ever
// read.
// Depends on gbn_pkg, gbn_ifs, gbn_store and gbn_run_calc.
`default_nettype none

module go_back_n_sender #(
    parameter int STORE_DEPTH = 64,
    parameter int MAX_WINDOW  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    gbn_cmd_if.sink          cmd,
    gbn_frame_if.source      frame,
    gbn_cfg_if.sink          cfg
);

    // index counters must hold STORE_DEPTH itself
    localparam int IDX_W  = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int WIDE_W = (IDX_W > gbn_pkg::SEQ_W) ? IDX_W : gbn_pkg::SEQ_W;
    localparam logic [IDX_W-1:0] DEPTH_V = IDX_W'(STORE_DEPTH);

    gbn_pkg::gbn_state_t state_reg, state_next;

    logic [IDX_W-1:0]          base_reg,   base_next;    // oldest unacked
    logic [IDX_W-1:0]          next_reg,   next_next;    // next never sent
    logic [IDX_W-1:0]          loaded_reg, loaded_next;  // bytes stored
    logic [IDX_W-1:0]          cur_reg,    cur_next;     // frame being sent
    logic [gbn_pkg::CNT_W-1:0] remain_reg, remain_next;  // frames left in run
    logic                      resend_reg, resend_next;
    logic                      ack_reg,    ack_next;     // run starts with resends
    logic [gbn_pkg::WIN_W-1:0] win_reg,    win_next;

    logic                      cmd_fire;
    logic                      frame_fire;
    logic                      wr_en;
    logic                      rd_en;
    logic [gbn_pkg::CNT_W-1:0] run_count;
    logic [WIDE_W-1:0]         ack_wide;
    logic [WIDE_W-1:0]         base_wide;
    logic [WIDE_W-1:0]         next_wide;
    logic [WIDE_W-1:0]         ack_plus;
    logic [WIDE_W-1:0]         cur_wide;
    logic                      ack_hit;
    logic                      store_full;

    assign cmd_fire   = cmd.valid && cmd.ready;
    assign frame_fire = frame.valid && frame.ready;
    assign cfg.ready  = 1'b1;

    assign ack_wide   = WIDE_W'(cmd.ack_seq);
    assign base_wide  = WIDE_W'(base_reg);
    assign next_wide  = WIDE_W'(next_reg);
    assign ack_plus   = ack_wide + WIDE_W'(1);
    assign ack_hit    = (ack_wide >= base_wide) && (ack_wide < next_wide);
    assign store_full = (loaded_reg >= DEPTH_V);
    assign cur_wide   = WIDE_W'(cur_reg);

    gbn_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[ADDR_W-1:0]),
        .wr_data (cmd.data_byte),
        .rd_en   (rd_en),
        .rd_addr (cur_reg[ADDR_W-1:0]),
        .rd_data (frame.frame_data)
    );

    gbn_run_calc #(
        .IDX_W      (IDX_W),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_run_calc (
        .base        (base_reg),
        .next_idx    (next_reg),
        .loaded      (loaded_reg),
        .win_size    (win_reg),
        .with_resend (ack_reg),
        .count       (run_count)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    // a load into a full store is dropped outright
                    if (cmd.operation == gbn_pkg::OP_LOAD && store_full)
                        state_next = gbn_pkg::ST_IDLE;
                    else
                        state_next = gbn_pkg::ST_PLAN;
                end
            end
            gbn_pkg::ST_PLAN:
            begin
                if (run_count == '0)
                    state_next = gbn_pkg::ST_IDLE;
                else
                    state_next = gbn_pkg::ST_READ;
            end
            gbn_pkg::ST_READ:
            begin
                state_next = gbn_pkg::ST_SHOW;
            end
            gbn_pkg::ST_SHOW:
            begin
                if (frame_fire)
                begin
                    if (remain_reg == gbn_pkg::CNT_W'(1))
                        state_next = gbn_pkg::ST_IDLE;
                    else
                        state_next = gbn_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        base_next   = base_reg;
        next_next   = next_reg;
        loaded_next = loaded_reg;
        cur_next    = cur_reg;
        remain_next = remain_reg;
        resend_next = resend_reg;
        ack_next    = ack_reg;
        win_next    = win_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        cmd.ready   = 1'b0;
        frame.valid = 1'b0;

        if (cfg.valid)
            win_next = cfg.win_size;

        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd_fire)
                begin
                    if (cmd.operation == gbn_pkg::OP_LOAD)
                    begin
                        ack_next = 1'b0;
                        cur_next = next_reg;
                        if (!store_full)
                        begin
                            wr_en       = 1'b1;
                            loaded_next = loaded_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        // run always starts at the (possibly advanced) base
                        ack_next = 1'b1;
                        if (ack_hit)
                        begin
                            base_next = IDX_W'(ack_plus);
                            cur_next  = IDX_W'(ack_plus);
                        end
                        else
                        begin
                            cur_next = base_reg;
                        end
                    end
                end
            end
            gbn_pkg::ST_PLAN:
            begin
                remain_next = run_count;
            end
            gbn_pkg::ST_READ:
            begin
                rd_en       = 1'b1;
                // indexes below next_reg have gone out before
                resend_next = (cur_reg < next_reg);
            end
            gbn_pkg::ST_SHOW:
            begin
                frame.valid = 1'b1;
                if (frame_fire)
                begin
                    cur_next    = cur_reg + IDX_W'(1);
                    remain_next = remain_reg - gbn_pkg::CNT_W'(1);
                    if (!resend_reg)
                        next_next = next_reg + IDX_W'(1);
                end
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    assign frame.frame_seq = cur_wide[gbn_pkg::SEQ_W-1:0];
    assign frame.is_resend = resend_reg;
    assign frame.last      = (remain_reg == gbn_pkg::CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gbn_pkg::ST_IDLE;
            base_reg   <= '0;
            next_reg   <= '0;
            loaded_reg <= '0;
            cur_reg    <= '0;
            remain_reg <= '0;
            resend_reg <= 1'b0;
            ack_reg    <= 1'b0;
            win_reg    <= gbn_pkg::WINDOW_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            next_reg   <= next_next;
            loaded_reg <= loaded_next;
            cur_reg    <= cur_next;
            remain_reg <= remain_next;
            resend_reg <= resend_next;
            ack_reg    <= ack_next;
            win_reg    <= win_next;
        end
    end

    // pointer ordering: base <= next <= loaded
    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (base_reg <= next_reg) && (next_reg <= loaded_reg))
        else $error("window pointers out of order");

    // a frame on the port always belongs to a run with frames left
    a_run_live: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid |-> (remain_reg != '0))
        else $error("frame shown with empty run");

    // the final frame taken hands control back to the input side
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_fire && frame.last) |=> cmd.ready)
        else $error("run did not end after last frame");

    // new frames go out only up to what has been stored
    a_new_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && !frame.is_resend) |-> (cur_reg < loaded_reg))
        else $error("new frame beyond stored data");

endmodule

`default_nettype wire
